>>> sv/sshit_pkg.sv
// Shared types and fixed widths for the segment/sphere hit test core.
// Depends on nothing; every other file imports it.
package sshit_pkg;

  localparam int unsigned CW  = 32;  // coordinate width
  localparam int unsigned MW  = 32;  // magnitude of a coordinate difference
  localparam int unsigned PW  = 64;  // product of two magnitudes
  localparam int unsigned SW  = 66;  // sum of three products
  localparam int unsigned TQ  = 32;  // fraction bits of the projection
  localparam int unsigned TW  = 33;  // projection including the value one
  localparam int unsigned MTW = 65;  // magnitude times projection
  localparam int unsigned RW  = 31;  // radius width
  localparam int unsigned R2W = 62;  // squared radius width
  localparam int unsigned LW  = 33;  // root width
  localparam int unsigned OQ  = 31;  // quotient bits of the offset
  localparam int unsigned NW  = 63;  // offset numerator width

  typedef struct packed {
    logic signed [CW-1:0] seg_a_x;
    logic signed [CW-1:0] seg_a_y;
    logic signed [CW-1:0] seg_a_z;
    logic signed [CW-1:0] seg_b_x;
    logic signed [CW-1:0] seg_b_y;
    logic signed [CW-1:0] seg_b_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [RW-1:0]        radius;
  } seg_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } seg_out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] c;
    logic [2:0][MW-1:0] dmag;
    logic [2:0]         dneg;
    logic [2:0][MW-1:0] wmag;
    logic [2:0]         wneg;
    logic [RW-1:0]      rad;
  } qitem_t;

  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] c;
    logic [2:0][MW-1:0] dmag;
    logic [2:0]         dneg;
    logic [R2W-1:0]     r2;
  } geo_t;

  typedef struct packed {
    geo_t          g;
    logic [SW-1:0] len2;
    logic [SW-1:0] rem;
    logic [TQ-1:0] q;
    logic          lez;
    logic          full;
  } tdiv_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][MW-1:0] dmag;
    logic [2:0]         dneg;
  } pt_t;

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][OQ-1:0] q;
    logic [LW-1:0]      len;
    logic [2:0][CW-1:0] p;
    logic [2:0]         dneg;
    logic               hit;
  } odiv_t;

endpackage

>>> sv/sshit_front.sv
// Front end: accepts a transaction and splits it into differences and signs.
// Depends on sshit_pkg.
module sshit_front import sshit_pkg::*; (
  input  logic    start_i,
  input  logic    q_full_i,
  input  seg_in_t req_i,
  output logic    busy_o,
  output logic    push_o,
  output qitem_t  item_o
);

  logic [2:0][CW-1:0] a, b, c;
  logic [CW:0]        d [3];
  logic [CW:0]        w [3];

  assign busy_o = q_full_i;
  assign push_o = start_i & ~q_full_i;

  always_comb begin
    a[0] = req_i.seg_a_x;
    a[1] = req_i.seg_a_y;
    a[2] = req_i.seg_a_z;
    b[0] = req_i.seg_b_x;
    b[1] = req_i.seg_b_y;
    b[2] = req_i.seg_b_z;
    c[0] = req_i.center_x;
    c[1] = req_i.center_y;
    c[2] = req_i.center_z;
    item_o.a   = a;
    item_o.c   = c;
    item_o.rad = req_i.radius;
    for (int i = 0; i < 3; i++) begin
      d[i] = {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
      w[i] = {c[i][CW-1], c[i]} - {a[i][CW-1], a[i]};
      item_o.dneg[i] = d[i][CW];
      item_o.wneg[i] = w[i][CW];
      item_o.dmag[i] = d[i][CW] ? MW'(-d[i]) : d[i][MW-1:0];
      item_o.wmag[i] = w[i][CW] ? MW'(-w[i]) : w[i][MW-1:0];
    end
  end

endmodule

>>> sv/sshit_queue.sv
// Short queue between front and back end; the back end drains it every cycle.
// Depends on sshit_pkg.
module sshit_queue import sshit_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qitem_t item_i,
  output logic   full_o,
  output logic   item_valid_o,
  output qitem_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qitem_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic            vld_q;
  qitem_t          rdata_q;

  assign pop    = (cnt_q != '0);
  assign full_o = (cnt_q == CntW'(Depth));

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
      vld_q  <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
    if (pop) begin
      rdata_q <= mem_q[rptr_q];
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = rdata_q;

endmodule

>>> sv/sshit_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a carried sideband.
// Depends on sshit_pkg.
module sshit_isqrt import sshit_pkg::*; #(
  parameter int unsigned NW_IN = 66,
  parameter int unsigned RBITS = 33,
  parameter int unsigned SBW   = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NW_IN-1:0] n_i,
  input  logic [SBW-1:0]   sb_i,
  output logic             valid_o,
  output logic [RBITS-1:0] root_o,
  output logic [SBW-1:0]   sb_o
);

  localparam int unsigned AW = 2 * RBITS + 2;

  logic             vld_q [RBITS];
  logic [AW-1:0]    rem_q [RBITS];
  logic [RBITS-1:0] res_q [RBITS];
  logic [SBW-1:0]   sb_q  [RBITS];

  for (genvar g = 0; g < RBITS; g++) begin : g_stage
    localparam int unsigned Bit = RBITS - 1 - g;
    logic             v_in;
    logic [AW-1:0]    rem_in, trial;
    logic [RBITS-1:0] res_in;
    logic [SBW-1:0]   sb_in;
    logic             take;

    if (g == 0) begin : g_src
      assign v_in   = valid_i;
      assign rem_in = AW'(n_i);
      assign res_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_src
      assign v_in   = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign res_in = res_q[g-1];
      assign sb_in  = sb_q[g-1];
    end

    assign trial = (AW'(res_in) << (Bit + 1)) | (AW'(1) << (2 * Bit));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= take ? rem_in - trial : rem_in;
      res_q[g] <= take ? (res_in | (RBITS'(1) << Bit)) : res_in;
      sb_q[g]  <= sb_in;
    end
  end

  assign valid_o = vld_q[RBITS-1];
  assign root_o  = res_q[RBITS-1];
  assign sb_o    = sb_q[RBITS-1];

endmodule

>>> sv/sshit_back.sv
// Back end: projection, closest point, distance test, roots and hit point.
// Depends on sshit_pkg and sshit_isqrt.
module sshit_back import sshit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  qitem_t   item_i,
  output logic     res_valid_o,
  output seg_out_t res_o
);

  // products
  logic               s1_vld_q;
  geo_t               s1_geo_q;
  logic [2:0][PW-1:0] s1_pdw_q, s1_pdd_q;
  logic [2:0]         s1_neg_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_pdw_q[i] <= PW'(item_i.dmag[i]) * PW'(item_i.wmag[i]);
      s1_pdd_q[i] <= PW'(item_i.dmag[i]) * PW'(item_i.dmag[i]);
      s1_neg_q[i] <= item_i.dneg[i] ^ item_i.wneg[i];
    end
    s1_geo_q.a    <= item_i.a;
    s1_geo_q.c    <= item_i.c;
    s1_geo_q.dmag <= item_i.dmag;
    s1_geo_q.dneg <= item_i.dneg;
    s1_geo_q.r2   <= R2W'(item_i.rad) * R2W'(item_i.rad);
  end

  // dot product halves and squared length
  logic          s2_vld_q;
  geo_t          s2_geo_q;
  logic [SW-1:0] s2_pos_d, s2_neg_d, s2_len2_d;
  logic [SW-1:0] s2_pos_q, s2_neg_q, s2_len2_q;

  always_comb begin
    s2_pos_d  = '0;
    s2_neg_d  = '0;
    s2_len2_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_neg_q[i]) begin
        s2_neg_d = s2_neg_d + SW'(s1_pdw_q[i]);
      end else begin
        s2_pos_d = s2_pos_d + SW'(s1_pdw_q[i]);
      end
      s2_len2_d = s2_len2_d + SW'(s1_pdd_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_geo_q  <= s1_geo_q;
    s2_pos_q  <= s2_pos_d;
    s2_neg_q  <= s2_neg_d;
    s2_len2_q <= s2_len2_d;
  end

  // classify projection
  logic          s3_vld_q;
  tdiv_t         s3_d, s3_q;
  logic [SW-1:0] s3_rem;

  always_comb begin
    s3_rem    = s2_pos_q - s2_neg_q;
    s3_d.g    = s2_geo_q;
    s3_d.len2 = s2_len2_q;
    s3_d.rem  = s3_rem;
    s3_d.q    = '0;
    s3_d.lez  = (s2_pos_q <= s2_neg_q);
    s3_d.full = (s2_pos_q > s2_neg_q) && (s3_rem >= s2_len2_q);
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  // projection divider
  tdiv_t dv_q     [TQ];
  logic  dv_vld_q [TQ];

  for (genvar g = 0; g < TQ; g++) begin : g_tdiv
    tdiv_t       prv, nxt;
    logic        pv;
    logic [SW:0] rem2, den;
    logic        ge;

    if (g == 0) begin : g_src
      assign prv = s3_q;
      assign pv  = s3_vld_q;
    end else begin : g_src
      assign prv = dv_q[g-1];
      assign pv  = dv_vld_q[g-1];
    end

    always_comb begin
      rem2     = {prv.rem, 1'b0};
      den      = {1'b0, prv.len2};
      ge       = (rem2 >= den);
      nxt      = prv;
      nxt.rem  = ge ? SW'(rem2 - den) : SW'(rem2);
      nxt.q    = {prv.q[TQ-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g] <= 1'b0;
      end else begin
        dv_vld_q[g] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[g] <= nxt;
    end
  end

  // projection value
  logic          st_vld_q;
  geo_t          st_geo_q;
  logic [SW-1:0] st_len2_q;
  logic [TW-1:0] st_t_d, st_t_q;

  always_comb begin
    if (dv_q[TQ-1].lez) begin
      st_t_d = '0;
    end else if (dv_q[TQ-1].full) begin
      st_t_d = TW'(1) << TQ;
    end else begin
      st_t_d = {1'b0, dv_q[TQ-1].q};
    end
  end

  always_ff @(posedge clk_i) begin
    st_geo_q  <= dv_q[TQ-1].g;
    st_len2_q <= dv_q[TQ-1].len2;
    st_t_q    <= st_t_d;
  end

  // step products
  logic                sm_vld_q;
  geo_t                sm_geo_q;
  logic [SW-1:0]       sm_len2_q;
  logic [2:0][MTW-1:0] sm_prod_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sm_prod_q[i] <= MTW'(st_geo_q.dmag[i]) * MTW'(st_t_q);
    end
    sm_geo_q  <= st_geo_q;
    sm_len2_q <= st_len2_q;
  end

  // closest point
  logic               sp_vld_q;
  geo_t               sp_geo_q;
  logic [SW-1:0]      sp_len2_q;
  logic [2:0][CW-1:0] sp_p_d, sp_p_q;
  logic [CW+1:0]      sp_full [3];
  logic [CW+1:0]      sp_step [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp_step[i] = {1'b0, sm_prod_q[i][MTW-1:TQ]};
      if (sm_geo_q.dneg[i]) begin
        sp_full[i] = {{2{sm_geo_q.a[i][CW-1]}}, sm_geo_q.a[i]} - sp_step[i];
      end else begin
        sp_full[i] = {{2{sm_geo_q.a[i][CW-1]}}, sm_geo_q.a[i]} + sp_step[i];
      end
      sp_p_d[i] = sp_full[i][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sp_geo_q  <= sm_geo_q;
    sp_len2_q <= sm_len2_q;
    sp_p_q    <= sp_p_d;
  end

  // distance components
  logic               se_vld_q;
  pt_t                se_pt_q;
  logic [R2W-1:0]     se_r2_q;
  logic [SW-1:0]      se_len2_q;
  logic [2:0][MW-1:0] se_emag_d, se_emag_q;
  logic [CW:0]        se_diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      se_diff[i]   = {sp_p_q[i][CW-1], sp_p_q[i]} - {sp_geo_q.c[i][CW-1], sp_geo_q.c[i]};
      se_emag_d[i] = se_diff[i][CW] ? MW'(-se_diff[i]) : se_diff[i][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    se_pt_q.p    <= sp_p_q;
    se_pt_q.dmag <= sp_geo_q.dmag;
    se_pt_q.dneg <= sp_geo_q.dneg;
    se_r2_q      <= sp_geo_q.r2;
    se_len2_q    <= sp_len2_q;
    se_emag_q    <= se_emag_d;
  end

  // distance squares
  logic               sq_vld_q;
  pt_t                sq_pt_q;
  logic [R2W-1:0]     sq_r2_q;
  logic [SW-1:0]      sq_len2_q;
  logic [2:0][PW-1:0] sq_esq_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_esq_q[i] <= PW'(se_emag_q[i]) * PW'(se_emag_q[i]);
    end
    sq_pt_q   <= se_pt_q;
    sq_r2_q   <= se_r2_q;
    sq_len2_q <= se_len2_q;
  end

  // squared distance
  logic           ss_vld_q;
  pt_t            ss_pt_q;
  logic [R2W-1:0] ss_r2_q;
  logic [SW-1:0]  ss_len2_q;
  logic [SW-1:0]  ss_dist2_q;

  always_ff @(posedge clk_i) begin
    ss_dist2_q <= SW'(sq_esq_q[0]) + SW'(sq_esq_q[1]) + SW'(sq_esq_q[2]);
    ss_pt_q    <= sq_pt_q;
    ss_r2_q    <= sq_r2_q;
    ss_len2_q  <= sq_len2_q;
  end

  // hit test
  logic           sh_vld_q;
  pt_t            sh_pt_q;
  logic [SW-1:0]  sh_len2_q;
  logic           sh_hit_d, sh_hit_q;
  logic [R2W-1:0] sh_gap_q;

  assign sh_hit_d = (ss_dist2_q <= SW'(ss_r2_q));

  always_ff @(posedge clk_i) begin
    sh_pt_q   <= ss_pt_q;
    sh_len2_q <= ss_len2_q;
    sh_hit_q  <= sh_hit_d;
    sh_gap_q  <= sh_hit_d ? ss_r2_q - ss_dist2_q[R2W-1:0] : '0;
  end

  // roots
  logic          rl_vld, rs_vld;
  logic [LW-1:0] rl_len, rs_root;
  pt_t           rl_pt;
  logic          rs_hit;

  sshit_isqrt #(
    .NW_IN(SW),
    .RBITS(LW),
    .SBW  ($bits(pt_t))
  ) u_len_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sh_vld_q),
    .n_i    (sh_len2_q),
    .sb_i   (sh_pt_q),
    .valid_o(rl_vld),
    .root_o (rl_len),
    .sb_o   (rl_pt)
  );

  sshit_isqrt #(
    .NW_IN(SW),
    .RBITS(LW),
    .SBW  (1)
  ) u_gap_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sh_vld_q),
    .n_i    (SW'(sh_gap_q)),
    .sb_i   (sh_hit_q),
    .valid_o(rs_vld),
    .root_o (rs_root),
    .sb_o   (rs_hit)
  );

  // offset numerators
  logic  so_vld_q;
  odiv_t so_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      so_q.rem[i] <= NW'(rl_pt.dmag[i]) * NW'(rs_root[OQ-1:0]);
    end
    so_q.q    <= '0;
    so_q.len  <= rl_len;
    so_q.p    <= rl_pt.p;
    so_q.dneg <= rl_pt.dneg;
    so_q.hit  <= rs_hit;
  end

  // offset divider
  odiv_t od_q     [OQ];
  logic  od_vld_q [OQ];

  for (genvar g = 0; g < OQ; g++) begin : g_odiv
    localparam int unsigned Bit = OQ - 1 - g;
    odiv_t       prv, nxt;
    logic        pv;
    logic [NW:0] dsh, rx;
    logic        ge;

    if (g == 0) begin : g_src
      assign prv = so_q;
      assign pv  = so_vld_q;
    end else begin : g_src
      assign prv = od_q[g-1];
      assign pv  = od_vld_q[g-1];
    end

    always_comb begin
      nxt = prv;
      dsh = (NW + 1)'(prv.len) << Bit;
      rx  = '0;
      ge  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        rx         = {1'b0, prv.rem[i]};
        ge         = (rx >= dsh);
        nxt.rem[i] = ge ? NW'(rx - dsh) : prv.rem[i];
        nxt.q[i]   = {prv.q[i][OQ-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        od_vld_q[g] <= 1'b0;
      end else begin
        od_vld_q[g] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      od_q[g] <= nxt;
    end
  end

  // hit point and saturation
  logic          sf_vld_q;
  seg_out_t      sf_d, sf_q;
  logic [OQ-1:0] sf_off [3];
  logic [CW+1:0] sf_sum [3];
  logic [CW-1:0] sf_h   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sf_off[i] = (od_q[OQ-1].len == '0) ? '0 : od_q[OQ-1].q[i];
      if (od_q[OQ-1].dneg[i]) begin
        sf_sum[i] = {{2{od_q[OQ-1].p[i][CW-1]}}, od_q[OQ-1].p[i]} + {3'b000, sf_off[i]};
      end else begin
        sf_sum[i] = {{2{od_q[OQ-1].p[i][CW-1]}}, od_q[OQ-1].p[i]} - {3'b000, sf_off[i]};
      end
      if (!sf_sum[i][CW+1] && (sf_sum[i][CW:CW-1] != 2'b00)) begin
        sf_h[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (sf_sum[i][CW+1] && (sf_sum[i][CW:CW-1] != 2'b11)) begin
        sf_h[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sf_h[i] = sf_sum[i][CW-1:0];
      end
    end
    sf_d.hit   = od_q[OQ-1].hit;
    sf_d.hit_x = od_q[OQ-1].hit ? sf_h[0] : '0;
    sf_d.hit_y = od_q[OQ-1].hit ? sf_h[1] : '0;
    sf_d.hit_z = od_q[OQ-1].hit ? sf_h[2] : '0;
  end

  always_ff @(posedge clk_i) begin
    sf_q <= sf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      st_vld_q <= 1'b0;
      sm_vld_q <= 1'b0;
      sp_vld_q <= 1'b0;
      se_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      ss_vld_q <= 1'b0;
      sh_vld_q <= 1'b0;
      so_vld_q <= 1'b0;
      sf_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= item_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      st_vld_q <= dv_vld_q[TQ-1];
      sm_vld_q <= st_vld_q;
      sp_vld_q <= sm_vld_q;
      se_vld_q <= sp_vld_q;
      sq_vld_q <= se_vld_q;
      ss_vld_q <= sq_vld_q;
      sh_vld_q <= ss_vld_q;
      so_vld_q <= rl_vld & rs_vld;
      sf_vld_q <= od_vld_q[OQ-1];
    end
  end

  assign res_valid_o = sf_vld_q;
  assign res_o       = sf_q;

endmodule

>>> sv/segment_sphere_hit_test_core.sv
// Segment/sphere hit test: one transaction per cycle while busy is low, fixed latency.
// done_o follows the queue read register and the back end, whose depth is set by the
// 32-stage projection divider, the 33-stage root pipelines and the 31-stage offset divider.
// One transaction per cycle; the receiver cannot stall, so busy stays low if QueueDepth > 1.
// rst_ni clears the queue and all pipeline valids asynchronously; payload is not reset.
// Depends on sshit_pkg, sshit_front, sshit_queue, sshit_back.
module segment_sphere_hit_test_core import sshit_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  seg_in_t  req_i,
  output logic     done_o,
  output seg_out_t res_o
);

  logic   q_full;
  logic   push;
  qitem_t front_item;
  logic   back_valid;
  qitem_t back_item;

  sshit_front u_front (
    .start_i (start),
    .q_full_i(q_full),
    .req_i   (req_i),
    .busy_o  (busy),
    .push_o  (push),
    .item_o  (front_item)
  );

  sshit_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (front_item),
    .full_o      (q_full),
    .item_valid_o(back_valid),
    .item_o      (back_item)
  );

  sshit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(back_valid),
    .item_i      (back_item),
    .res_valid_o (done_o),
    .res_o       (res_o)
  );

endmodule
